// File: hw/rtl/mdrq_pkg.sv
// package for the message display rotation queue
// shared constants, codes and types; no dependencies
package mdrq_pkg;
	localparam int ExpDepth = 16;
	localparam int PermDepth = 16;
	localparam int ExpCntW = $clog2(ExpDepth + 1);
	localparam int PermCntW = $clog2(PermDepth + 1);

	// both stores are built from rows of this many cells; counts bound the live part
	localparam int ChainDepth = (ExpDepth > PermDepth) ? ExpDepth : PermDepth;
	localparam int ChainCntW = $clog2(ChainDepth + 1);
	localparam int ChainIdxW = (ChainDepth > 1) ? $clog2(ChainDepth) : 1;

	localparam logic [1:0] KIND_NOTIFY = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_POP = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [15:0] DEF_LIFETIME_RST = 16'd1000;
	localparam logic [15:0] ROT_INTERVAL_RST = 16'd10000;

	localparam logic CFG_DEF_LIFETIME = 1'b0;
	localparam logic CFG_ROT_INTERVAL = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic signed [31:0] timeout_ms;
		logic [31:0] target_id;
		logic [15:0] tick_ms;
	} in_item_t;

	typedef struct packed {
		logic [31:0] assigned_id;
		logic [1:0] status;
		logic visible;
		logic [31:0] shown_id;
	} out_item_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic append;     // write into the cell at the fill boundary
		logic remove;     // shift left from the removal point
		logic dec_head;   // head lifetime takes a tick
	} cell_ctl_t;

	// saturating signed subtract of an unsigned 16 bit amount
	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
			input logic [15:0] d);
		logic signed [32:0] r;
		r = {a[31], a} - $signed({17'd0, d});
		if (r < -33'sd2147483648) sat_sub = 32'sh8000_0000;
		else sat_sub = r[31:0];
	endfunction
endpackage

// File: hw/rtl/mdrq_if.sv
// valid/ready channel carrying one item
// depends on mdrq_pkg for the item types
interface mdrq_in_if;
	logic valid;
	logic ready;
	mdrq_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mdrq_out_if;
	logic valid;
	logic ready;
	mdrq_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/message_display_rotation_queue_unit.sv
// top level of the message display rotation queue
// depends on mdrq_pkg, mdrq_if, mdrq_chain
//
// Two rows of cells hold the expiring and permanent messages; a short sequencer
// runs each item through its steps in order: the input transfer, the store update
// (append, removal by id, pop, head aging), the expiry and rotation step, and the
// result load. Pop-top of a non-empty permanent store passes through the rotation
// step once more for its 1 ms tick. A new item is taken once the previous result
// has gone into the output register; a result that waits there holds the next
// item in its result step until the output is free.
// There is no clearing pass: count registers bound every read.
module message_display_rotation_queue_unit (
	input logic clk,
	input logic arst_n,
	mdrq_in_if.sink in_ch,
	mdrq_out_if.source out_ch,
	input logic cfg_we,
	input logic cfg_index,
	input logic [15:0] cfg_wdata
);
	localparam int ED = mdrq_pkg::ExpDepth;
	localparam int PD = mdrq_pkg::PermDepth;
	localparam int EW = mdrq_pkg::ExpCntW;
	localparam int PW = mdrq_pkg::PermCntW;
	localparam int CD = mdrq_pkg::ChainDepth;
	localparam int CW = mdrq_pkg::ChainCntW;
	localparam int CIW = mdrq_pkg::ChainIdxW;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_AGE = 4'b0010,
		S_ROT = 4'b0100,
		S_OUT = 4'b1000
	} state_t;

	state_t state_q;
	mdrq_pkg::in_item_t item_q;
	logic [15:0] def_life_q, rot_int_q;
	logic [EW-1:0] ecnt_q;
	logic [PW-1:0] pcnt_q;
	logic cur_v_q;
	logic [PW-1:0] cur_q;
	logic signed [31:0] rot_q;
	logic [31:0] next_id_q;
	logic vis_q;
	logic [31:0] shid_q;
	logic [1:0] status_q;
	logic [31:0] aid_q;
	logic tick_q;          // run tick in the rotate step
	logic [15:0] dt_q;
	logic out_v_q;
	mdrq_pkg::out_item_t out_q;

	// chain controls
	logic e_app, e_rm, e_dec, p_app, p_rm;
	logic [CW-1:0] e_rm_idx;
	logic [CW-1:0] p_rm_idx;
	logic [31:0] e_head_id, p_found_unused;
	logic signed [31:0] e_head_life;
	logic [31:0] e_ids [CD];
	logic [31:0] p_ids [CD];
	logic e_found, p_found;
	logic [CW-1:0] e_fidx;
	logic [CW-1:0] p_fidx;
	logic signed [31:0] eff_to;
	logic [31:0] p_head_unused_l;

	assign eff_to = (item_q.timeout_ms == -32'sd1) ?
		$signed({16'd0, def_life_q}) : item_q.timeout_ms;

	mdrq_chain u_exp (
		.clk(clk), .append(e_app), .remove(e_rm), .dec_head(e_dec),
		.count(CW'(ecnt_q)), .rm_idx(e_rm_idx), .tick_ms(dt_q),
		.new_id(next_id_q), .new_life(eff_to), .match_id(item_q.target_id),
		.head_id(e_head_id), .head_life(e_head_life), .ids(e_ids),
		.found(e_found), .found_idx(e_fidx)
	);

	mdrq_chain u_perm (
		.clk(clk), .append(p_app), .remove(p_rm), .dec_head(1'b0),
		.count(CW'(pcnt_q)), .rm_idx(p_rm_idx), .tick_ms(dt_q),
		.new_id(next_id_q), .new_life(32'sd0), .match_id(item_q.target_id),
		.head_id(p_found_unused), .head_life(p_head_unused_l), .ids(p_ids),
		.found(p_found), .found_idx(p_fidx)
	);

	logic is_notify, is_close, is_pop, perm_new;
	assign is_notify = item_q.kind == mdrq_pkg::KIND_NOTIFY;
	assign is_close = item_q.kind == mdrq_pkg::KIND_CLOSE;
	assign is_pop = item_q.kind == mdrq_pkg::KIND_POP;
	assign perm_new = eff_to == 32'sd0;

	// age step: appends, removals by id, pop, and head aging for a tick happen here
	always_comb begin
		e_app = 1'b0; e_rm = 1'b0; e_dec = 1'b0; p_app = 1'b0; p_rm = 1'b0;
		e_rm_idx = '0; p_rm_idx = '0;
		if (state_q == S_AGE) begin
			if (is_notify) begin
				p_app = perm_new && (pcnt_q < PW'(PD));
				e_app = !perm_new && (ecnt_q < EW'(ED));
			end else if (is_close && item_q.target_id != 32'd0) begin
				if (p_found) begin
					p_rm = 1'b1; p_rm_idx = p_fidx;
				end else if (e_found) begin
					e_rm = 1'b1; e_rm_idx = e_fidx;
				end
			end else if (is_pop && pcnt_q != '0) begin
				p_rm = 1'b1;
			end
			// a tick ages the head now; its removal follows in the rotate step
			e_dec = (item_q.kind == mdrq_pkg::KIND_TICK) && (ecnt_q != '0);
		end
		// expired head drops in the rotate step, once the pop has aged it
		if (state_q == S_ROT && tick_q && !is_pop && ecnt_q != '0 &&
				e_head_life <= 32'sd0) begin
			e_rm = 1'b1; e_rm_idx = '0;
		end
		if (state_q == S_ROT && tick_q && is_pop && ecnt_q != '0) begin
			e_dec = 1'b1;
		end
	end

	// pop ages in rotate step, then the expired check follows in a second rotate pass
	logic signed [31:0] rot_sub;
	logic [PW-1:0] cur_inc;
	assign rot_sub = mdrq_pkg::sat_sub(rot_q, dt_q);
	assign cur_inc = cur_q + PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			item_q <= '0;
			def_life_q <= mdrq_pkg::DEF_LIFETIME_RST;
			rot_int_q <= mdrq_pkg::ROT_INTERVAL_RST;
			ecnt_q <= '0;
			pcnt_q <= '0;
			cur_v_q <= 1'b0;
			cur_q <= '0;
			rot_q <= '0;
			next_id_q <= 32'd1;
			vis_q <= 1'b0;
			shid_q <= '0;
			status_q <= mdrq_pkg::ST_OK;
			aid_q <= '0;
			dt_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			tick_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == mdrq_pkg::CFG_DEF_LIFETIME) def_life_q <= cfg_wdata;
				else rot_int_q <= cfg_wdata;
			end
			// the result step loads the register itself
			if (out_ch.ready && state_q != S_OUT) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						item_q <= in_ch.data;
						dt_q <= in_ch.data.tick_ms;
						state_q <= S_AGE;
					end
				end
				S_AGE: begin
					aid_q <= is_notify ? next_id_q : 32'd0;
					tick_q <= (item_q.kind == mdrq_pkg::KIND_TICK) ||
						(is_pop && pcnt_q != '0);
					if (is_notify) begin
						next_id_q <= (next_id_q == 32'hFFFF_FFFF) ? 32'd1 : next_id_q + 32'd1;
						if (perm_new) begin
							if (pcnt_q < PW'(PD)) begin
								status_q <= mdrq_pkg::ST_OK;
								pcnt_q <= pcnt_q + PW'(1);
								if (!cur_v_q) begin
									cur_v_q <= 1'b1; cur_q <= pcnt_q;
								end
							end else status_q <= mdrq_pkg::ST_FULL;
						end else begin
							if (ecnt_q < EW'(ED)) begin
								status_q <= mdrq_pkg::ST_OK;
								ecnt_q <= ecnt_q + EW'(1);
							end else status_q <= mdrq_pkg::ST_FULL;
						end
					end else if (is_close) begin
						if (item_q.target_id == 32'd0) status_q <= mdrq_pkg::ST_NOT_FOUND;
						else if (p_found) begin
							status_q <= mdrq_pkg::ST_OK;
							pcnt_q <= pcnt_q - PW'(1);
							if (cur_v_q) begin
								if (PW'(p_fidx) < cur_q) cur_q <= cur_q - PW'(1);
								else if (PW'(p_fidx) == cur_q && cur_q >= pcnt_q - PW'(1)) begin
									cur_q <= '0;
									if (pcnt_q == PW'(1)) cur_v_q <= 1'b0;
								end
							end
						end else if (e_found) begin
							status_q <= mdrq_pkg::ST_OK;
							ecnt_q <= ecnt_q - EW'(1);
						end else status_q <= mdrq_pkg::ST_NOT_FOUND;
					end else begin
						status_q <= mdrq_pkg::ST_OK;
						if (is_pop && pcnt_q != '0) begin
							pcnt_q <= pcnt_q - PW'(1);
							if (cur_v_q) begin
								if (cur_q == '0) cur_v_q <= 1'b0;
								else cur_q <= cur_q - PW'(1);
							end
							dt_q <= 16'd1;
						end
					end
					state_q <= S_ROT;
				end
				S_ROT: begin
					// tick: the head was aged already (pop ages it this cycle)
					if (tick_q && is_pop) begin
						// second pass handled by going around once more as a tick
						item_q.kind <= mdrq_pkg::KIND_TICK;
						state_q <= S_ROT;
						tick_q <= 1'b1;
					end else begin
						if (tick_q) begin
							if (ecnt_q != '0 && e_head_life <= 32'sd0) begin
								ecnt_q <= ecnt_q - EW'(1);
								if (ecnt_q == EW'(1)) begin
									// rotation path after drop
									rot_q <= (rot_sub <= 32'sd0) ? $signed({16'd0, rot_int_q})
										: rot_sub;
								end
							end else if (ecnt_q == '0) begin
								rot_q <= (rot_sub <= 32'sd0) ? $signed({16'd0, rot_int_q})
									: rot_sub;
							end
							if ((ecnt_q == '0 || (ecnt_q == EW'(1) && e_head_life <= 32'sd0))
									&& rot_sub <= 32'sd0 && cur_v_q) begin
								if (pcnt_q == '0) cur_v_q <= 1'b0;
								cur_q <= (cur_inc >= pcnt_q) ? '0 : cur_inc;
							end
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_v_q || out_ch.ready) begin
						if (tick_q) begin
							if (ecnt_q != '0) begin
								vis_q <= 1'b1; shid_q <= e_head_id;
								out_q.visible <= 1'b1; out_q.shown_id <= e_head_id;
							end else if (cur_v_q && cur_q < pcnt_q) begin
								vis_q <= 1'b1; shid_q <= p_ids[CIW'(cur_q)];
								out_q.visible <= 1'b1;
								out_q.shown_id <= p_ids[CIW'(cur_q)];
							end else begin
								vis_q <= 1'b0; shid_q <= '0;
								out_q.visible <= 1'b0; out_q.shown_id <= '0;
							end
						end else begin
							out_q.visible <= vis_q; out_q.shown_id <= shid_q;
						end
						out_q.assigned_id <= aid_q;
						out_q.status <= status_q;
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready = state_q == S_IDLE;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;
endmodule

// File: hw/rtl/mdrq_cell.sv
// one queue cell: id and lifetime, shifts toward the head on removal
// depends on mdrq_pkg
module mdrq_cell (
	input logic clk,
	input mdrq_pkg::cell_ctl_t ctl,
	input logic is_head,
	input logic [15:0] tick_ms,
	input logic [31:0] new_id,
	input logic signed [31:0] new_life,
	input logic [31:0] right_id,
	input logic signed [31:0] right_life,
	input logic [31:0] match_id,
	output logic [31:0] id,
	output logic signed [31:0] life,
	output logic match
);
	logic [31:0] id_q;
	logic signed [31:0] life_q;

	always_ff @(posedge clk) begin
		if (ctl.append) begin
			id_q <= new_id;
			life_q <= new_life;
		end else if (ctl.remove) begin
			id_q <= right_id;
			life_q <= right_life;
		end else if (ctl.dec_head && is_head) begin
			life_q <= mdrq_pkg::sat_sub(life_q, tick_ms);
		end
	end

	assign id = id_q;
	assign life = life_q;
	assign match = (id_q == match_id);
endmodule

// File: hw/rtl/mdrq_chain.sv
// row of cells forming one ordered store with first-match search
// depends on mdrq_pkg, mdrq_cell
module mdrq_chain (
	input logic clk,
	input logic append,
	input logic remove,
	input logic dec_head,
	input logic [mdrq_pkg::ChainCntW-1:0] count,
	input logic [mdrq_pkg::ChainCntW-1:0] rm_idx,
	input logic [15:0] tick_ms,
	input logic [31:0] new_id,
	input logic signed [31:0] new_life,
	input logic [31:0] match_id,
	output logic [31:0] head_id,
	output logic signed [31:0] head_life,
	output logic [31:0] ids [mdrq_pkg::ChainDepth],
	output logic found,
	output logic [mdrq_pkg::ChainCntW-1:0] found_idx
);
	localparam int Depth = mdrq_pkg::ChainDepth;
	localparam int CntW = mdrq_pkg::ChainCntW;

	logic signed [31:0] lifes [Depth];
	logic [Depth-1:0] hit;

	for (genvar g = 0; g < Depth; g++) begin : g_cell
		mdrq_pkg::cell_ctl_t c;
		logic [31:0] rid;
		logic signed [31:0] rlife;
		logic m;
		assign c.append = append && (count == CntW'(g));
		assign c.remove = remove && (CntW'(g) >= rm_idx);
		assign c.dec_head = dec_head;
		if (g + 1 < Depth) begin : g_r
			assign rid = ids[g+1];
			assign rlife = lifes[g+1];
		end else begin : g_e
			assign rid = ids[g];
			assign rlife = lifes[g];
		end
		mdrq_cell u_cell (
			.clk(clk), .ctl(c), .is_head(g == 0), .tick_ms(tick_ms),
			.new_id(new_id), .new_life(new_life), .right_id(rid),
			.right_life(rlife), .match_id(match_id),
			.id(ids[g]), .life(lifes[g]), .match(m)
		);
		assign hit[g] = m && (CntW'(g) < count);
	end

	always_comb begin
		found = 1'b0;
		found_idx = '0;
		for (int i = Depth - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				found_idx = CntW'(i);
			end
		end
	end

	assign head_id = ids[0];
	assign head_life = lifes[0];
endmodule
